>>> hdl/html_entity_to_utf8_decoder_macros.svh
// ============================================================================
// HTML entity decoder assertion macros
// Concurrent assertion wrappers shared by the decoder modules. The bodies
// are empty when SYNTHESIS is defined.
// ============================================================================
`ifndef HTML_ENTITY_TO_UTF8_DECODER_MACROS_SVH
`define HTML_ENTITY_TO_UTF8_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Check on every clock edge outside reset
`define HED_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every clock edge, reset included
`define HED_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define HED_ASSERT(lbl, prop, msg)
`define HED_ASSERT_RST(lbl, prop, msg)

`endif

`endif

>>> hdl/hed_pkg.sv
// ============================================================================
// HTML entity decoder package
// Shared constants, the front-to-back command type and entity table lookups.
// ============================================================================
`timescale 1ns / 1ps

package hed_pkg;

   // Reference buffer and counters
   localparam int PENDING_DEPTH      = 10;
   localparam int PEND_CNT_W         = $clog2(PENDING_DEPTH + 1);
   localparam int MAX_DIGITS_DEFAULT = 7;
   localparam int CODE_W             = 21;
   localparam int TAIL_LEN_W         = 3;
   localparam int TOTAL_W            = 4;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [CODE_W-1:0] CODE_MAX = 21'h1FFFFF;

   // Byte codes
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_X_LO  = 8'h78;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;

   // UTF-8 range limits and byte marks
   localparam logic [CODE_W-1:0] UTF8_MAX1 = 21'h00007F;
   localparam logic [CODE_W-1:0] UTF8_MAX2 = 21'h0007FF;
   localparam logic [CODE_W-1:0] UTF8_MAX3 = 21'h00FFFF;
   localparam logic [7:0] UTF8_LEAD2 = 8'b11000000;
   localparam logic [7:0] UTF8_LEAD3 = 8'b11100000;
   localparam logic [7:0] UTF8_LEAD4 = 8'b11110000;
   localparam logic [7:0] UTF8_CONT  = 8'b10000000;
   localparam logic [7:0] UTF8_MASK  = 8'b00111111;

   // Named entities: quot, amp, lt, gt
   localparam logic [3:0] CAND_ALL = 4'hF;

   // One unit of work for the output side: verbatim bytes, then a tail
   typedef struct packed {
      logic [PEND_CNT_W-1:0]          vcount;
      logic [PENDING_DEPTH-1:0][7:0]  vbytes;
      logic [TAIL_LEN_W-1:0]          tail_len;
      logic                           tail_ref;
      logic [CODE_W-1:0]              tail_cp;
      logic [TOTAL_W-1:0]             total;
   } cmd_type;

   function automatic logic [2:0] ent_len(input logic [1:0] idx);
      logic [2:0] len;
      unique case (idx)
         2'd0: len = 3'd4;
         2'd1: len = 3'd3;
         2'd2: len = 3'd2;
         2'd3: len = 3'd2;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] ent_char(input logic [1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         2'd0: ch = 8'h22;
         2'd1: ch = 8'h26;
         2'd2: ch = 8'h3C;
         2'd3: ch = 8'h3E;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] ent_name_char(input logic [1:0] idx,
                                                input logic [1:0] pos);
      logic [7:0] ch;
      unique case ({idx, pos})
         4'b00_00: ch = 8'h71;  // q
         4'b00_01: ch = 8'h75;  // u
         4'b00_10: ch = 8'h6F;  // o
         4'b00_11: ch = 8'h74;  // t
         4'b01_00: ch = 8'h61;  // a
         4'b01_01: ch = 8'h6D;  // m
         4'b01_10: ch = 8'h70;  // p
         4'b10_00: ch = 8'h6C;  // l
         4'b10_01: ch = 8'h74;  // t
         4'b11_00: ch = 8'h67;  // g
         4'b11_01: ch = 8'h74;  // t
         default:  ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [TAIL_LEN_W-1:0] utf8_len(input logic [CODE_W-1:0] cp);
      logic [TAIL_LEN_W-1:0] len;
      priority if (cp <= UTF8_MAX1) len = TAIL_LEN_W'(1);
      else if (cp <= UTF8_MAX2)     len = TAIL_LEN_W'(2);
      else if (cp <= UTF8_MAX3)     len = TAIL_LEN_W'(3);
      else                          len = TAIL_LEN_W'(4);
      return len;
   endfunction

endpackage

>>> hdl/hed_if.sv
// ============================================================================
// HTML entity decoder channel interfaces
// Valid/ready request and response channels with their payload.
// ============================================================================
`timescale 1ns / 1ps

interface hed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface hed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       from_reference;
   logic       last_of_run;

   modport source (output valid, output out_byte, output from_reference,
                   output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input from_reference,
                   input last_of_run, output ready);
endinterface

>>> hdl/hed_front.sv
// ============================================================================
// HTML entity decoder front end
// Accepts text bytes, tracks the reference parser and issues one output
// command per request that yields bytes.
// ============================================================================
`timescale 1ns / 1ps
`include "html_entity_to_utf8_decoder_macros.svh"

module hed_front #(
   parameter int MAX_DIGITS = hed_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   hed_req_if.sink           req,
   output hed_pkg::cmd_type  cmd,
   output logic              cmd_push,
   input  logic              cmd_full
);

   localparam int DIG_W = $clog2(MAX_DIGITS + 1);
   localparam int PCW   = hed_pkg::PEND_CNT_W;
   localparam int CW    = hed_pkg::CODE_W;
   localparam int DEPTH = hed_pkg::PENDING_DEPTH;

   typedef enum logic [4:0] {
      MODE_TEXT = 5'b00001,
      MODE_NAME = 5'b00010,
      MODE_HASH = 5'b00100,
      MODE_DEC  = 5'b01000,
      MODE_HEX  = 5'b10000
   } mode_type;

   mode_type                  mode_ff,   mode_in, push_mode;
   logic [DEPTH-1:0][7:0]     pend_ff,   pend_in, pend_push;
   logic [PCW-1:0]            pcount_ff, pcount_in;
   logic [CW-1:0]             acc_ff,    acc_in;
   logic                      ovf_ff,    ovf_in;
   logic [DIG_W-1:0]          dcount_ff, dcount_in;
   logic [3:0]                cand_ff,   cand_in, push_cand;

   logic                      accept;
   logic [7:0]                b;
   logic                      eot;
   logic [PCW-1:0]            pos;
   logic                      push_room;
   logic                      is_dec, is_hex_lo, is_hex_up, use_hex;
   logic                      digit_ok, digit_take;
   logic [3:0]                digit_val;
   logic [CW+3:0]             acc_wide;
   logic                      acc_over;
   logic [CW-1:0]             acc_sat;
   logic [3:0]                name_keep;
   logic                      name_hit;
   logic [7:0]                name_out;
   logic                      do_push, do_fail, do_succ, push_digit;
   logic [CW-1:0]             succ_cp;

   // Handshake: take a request whenever the queue has room
   assign req.ready = !cmd_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.in_byte;
   assign eot       = req.end_of_text;
   assign pos       = pcount_ff - PCW'(1);
   assign push_room = pcount_ff < PCW'(DEPTH);

   // Classify digits and advance the code accumulator
   always_comb begin
      is_dec    = (b >= 8'h30) && (b <= 8'h39);
      is_hex_lo = (b >= 8'h61) && (b <= 8'h66);
      is_hex_up = (b >= 8'h41) && (b <= 8'h46);
      use_hex   = (mode_ff == MODE_HEX);
      digit_ok  = is_dec || (use_hex && (is_hex_lo || is_hex_up));
      digit_val = is_dec ? b[3:0] : (b[3:0] + 4'd9);
      digit_take = digit_ok && (dcount_ff < DIG_W'(MAX_DIGITS)) && push_room;
      if (use_hex) begin
         acc_wide = {acc_ff, 4'b0000} + (CW+4)'(digit_val);
      end else begin
         acc_wide = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                    + (CW+4)'(digit_val);
      end
      acc_over = acc_wide > (CW+4)'(hed_pkg::CODE_MAX);
      acc_sat  = acc_over ? hed_pkg::CODE_MAX : acc_wide[CW-1:0];
   end

   // Match the named entities still possible at this position
   always_comb begin
      name_keep = '0;
      name_hit  = 1'b0;
      name_out  = '0;
      for (int i = 3; i >= 0; i--) begin
         if (cand_ff[i] && ({1'b0, hed_pkg::ent_len(2'(i))} == pos)) begin
            name_hit = 1'b1;
            name_out = hed_pkg::ent_char(2'(i));
         end
         if (cand_ff[i] && (pos < {1'b0, hed_pkg::ent_len(2'(i))}) &&
             (hed_pkg::ent_name_char(2'(i), pos[1:0]) == b)) begin
            name_keep[i] = 1'b1;
         end
      end
   end

   // Buffer image with the current byte appended
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         pend_push[i] = (pcount_ff == PCW'(i)) ? b : pend_ff[i];
      end
   end

   // Decide: extend the reference, finish it, or drop it verbatim
   always_comb begin
      do_push    = 1'b0;
      do_fail    = 1'b0;
      do_succ    = 1'b0;
      push_digit = 1'b0;
      succ_cp    = '0;
      push_mode  = mode_ff;
      push_cand  = cand_ff;
      unique case (mode_ff)
         MODE_TEXT: begin
            do_fail = 1'b1;
         end
         MODE_NAME: begin
            if ((pos == '0) && (b == hed_pkg::CHAR_HASH)) begin
               if (push_room) begin
                  do_push   = 1'b1;
                  push_mode = MODE_HASH;
               end else begin
                  do_fail = 1'b1;
               end
            end else if (b == hed_pkg::CHAR_SEMI) begin
               if (name_hit) begin
                  do_succ = 1'b1;
                  succ_cp = CW'(name_out);
               end else begin
                  do_fail = 1'b1;
               end
            end else if ((name_keep != '0) && push_room) begin
               do_push   = 1'b1;
               push_cand = name_keep;
            end else begin
               do_fail = 1'b1;
            end
         end
         MODE_HASH: begin
            if ((b == hed_pkg::CHAR_X_LO) || (b == hed_pkg::CHAR_X_UP)) begin
               if (push_room) begin
                  do_push   = 1'b1;
                  push_mode = MODE_HEX;
               end else begin
                  do_fail = 1'b1;
               end
            end else if (digit_take) begin
               do_push    = 1'b1;
               push_digit = 1'b1;
               push_mode  = MODE_DEC;
            end else begin
               do_fail = 1'b1;
            end
         end
         MODE_DEC, MODE_HEX: begin
            if (b == hed_pkg::CHAR_SEMI) begin
               if ((dcount_ff != '0) && !ovf_ff) begin
                  do_succ = 1'b1;
                  succ_cp = acc_ff;
               end else begin
                  do_fail = 1'b1;
               end
            end else if (digit_take) begin
               do_push    = 1'b1;
               push_digit = 1'b1;
            end else begin
               do_fail = 1'b1;
            end
         end
         default: begin
            do_fail = 1'b1;
         end
      endcase
   end

   // Next state and the command for the output side
   always_comb begin
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      pcount_in = pcount_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      dcount_in = dcount_ff;
      cand_in   = cand_ff;

      cmd.vcount   = '0;
      cmd.vbytes   = pend_push;
      cmd.tail_len = '0;
      cmd.tail_ref = 1'b0;
      cmd.tail_cp  = '0;

      if (do_succ) begin
         mode_in      = MODE_TEXT;
         pcount_in    = '0;
         acc_in       = '0;
         ovf_in       = 1'b0;
         dcount_in    = '0;
         cand_in      = hed_pkg::CAND_ALL;
         cmd.tail_len = hed_pkg::utf8_len(succ_cp);
         cmd.tail_ref = 1'b1;
         cmd.tail_cp  = succ_cp;
      end

      if (do_fail) begin
         cmd.vcount = pcount_ff;
         cmd.vbytes = pend_ff;
         mode_in    = MODE_TEXT;
         pcount_in  = '0;
         acc_in     = '0;
         ovf_in     = 1'b0;
         dcount_in  = '0;
         cand_in    = hed_pkg::CAND_ALL;
         if ((b == hed_pkg::CHAR_AMP) && !eot) begin
            // open a new reference
            mode_in    = MODE_NAME;
            pcount_in  = PCW'(1);
            pend_in[0] = hed_pkg::CHAR_AMP;
         end else begin
            cmd.tail_len = hed_pkg::TAIL_LEN_W'(1);
            cmd.tail_cp  = CW'(b);
         end
      end

      if (do_push) begin
         if (eot) begin
            // flush the whole reference including this byte
            cmd.vcount = pcount_ff + PCW'(1);
            mode_in    = MODE_TEXT;
            pcount_in  = '0;
            acc_in     = '0;
            ovf_in     = 1'b0;
            dcount_in  = '0;
            cand_in    = hed_pkg::CAND_ALL;
         end else begin
            pend_in   = pend_push;
            pcount_in = pcount_ff + PCW'(1);
            mode_in   = push_mode;
            cand_in   = push_cand;
            if (push_digit) begin
               acc_in    = acc_sat;
               ovf_in    = ovf_ff | acc_over;
               dcount_in = dcount_ff + DIG_W'(1);
            end
         end
      end

      cmd.total = hed_pkg::TOTAL_W'(cmd.vcount) + hed_pkg::TOTAL_W'(cmd.tail_len);
   end

   assign cmd_push = accept && (cmd.total != '0);

   // Parser control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_TEXT;
         pcount_ff <= '0;
         acc_ff    <= '0;
         ovf_ff    <= 1'b0;
         dcount_ff <= '0;
         cand_ff   <= hed_pkg::CAND_ALL;
      end else if (accept) begin
         mode_ff   <= mode_in;
         pcount_ff <= pcount_in;
         acc_ff    <= acc_in;
         ovf_ff    <= ovf_in;
         dcount_ff <= dcount_in;
         cand_ff   <= cand_in;
      end
   end

   // Held reference bytes
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

   `HED_ASSERT(a_text_mode_empty, mode_ff == MODE_TEXT |-> pcount_ff == '0, "bytes held in text")
   `HED_ASSERT_RST(a_reset_clears, reset |=> (mode_ff == MODE_TEXT), "reset left a reference open")

endmodule

>>> hdl/hed_cmd_queue.sv
// ============================================================================
// HTML entity decoder command queue
// Short FIFO of output commands between the front end and the emitter.
// ============================================================================
`timescale 1ns / 1ps
`include "html_entity_to_utf8_decoder_macros.svh"

module hed_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hed_pkg::cmd_type  push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output hed_pkg::cmd_type  pop_data
);

   localparam int DEPTH = hed_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hed_pkg::cmd_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store commands
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `HED_ASSERT(a_no_overflow, push |-> !full, "command pushed into a full queue")
   `HED_ASSERT(a_no_underflow, pop |-> pop_valid, "command popped from an empty queue")

endmodule

>>> hdl/hed_back.sv
// ============================================================================
// HTML entity decoder emitter
// Takes commands from the queue and sends their bytes, one per cycle while
// the response is not stalled, through a registered response stage.
// ============================================================================
`timescale 1ns / 1ps
`include "html_entity_to_utf8_decoder_macros.svh"

module hed_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  hed_pkg::cmd_type  q_data,
   output logic              q_pop,
   hed_rsp_if.source         rsp
);

   localparam int TW  = hed_pkg::TOTAL_W;
   localparam int CW  = hed_pkg::CODE_W;
   localparam int LW  = hed_pkg::TAIL_LEN_W;

   hed_pkg::cmd_type  work_ff,   work_in;
   logic              work_valid_ff, work_valid_in;
   logic [TW-1:0]     pos_ff,    pos_in;
   logic [7:0]        byte_ff,   byte_in;
   logic              ref_ff,    ref_in;
   logic              last_ff,   last_in;
   logic              valid_ff,  valid_in;

   logic              out_free;
   logic              emit;
   logic              at_last;
   logic [TW-1:0]     tail_pos;

   // Byte k of the UTF-8 encoding of cp, len bytes long
   function automatic logic [7:0] utf8_byte(input logic [CW-1:0] cp,
                                            input logic [LW-1:0] len,
                                            input logic [1:0]    k);
      logic [1:0] j;
      logic [5:0] grp;
      logic [7:0] val;
      j = 2'(len - LW'(1)) - k;
      unique case (j)
         2'd0: grp = cp[5:0];
         2'd1: grp = cp[11:6];
         2'd2: grp = cp[17:12];
         2'd3: grp = 6'(cp[20:18]);
      endcase
      if (k != 2'd0) begin
         val = hed_pkg::UTF8_CONT | ({2'b00, grp} & hed_pkg::UTF8_MASK);
      end else begin
         unique case (len)
            LW'(1):  val = {1'b0, cp[6:0]};
            LW'(2):  val = hed_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
            LW'(3):  val = hed_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]};
            LW'(4):  val = hed_pkg::UTF8_LEAD4 | {5'b00000, cp[20:18]};
            default: val = 8'h00;
         endcase
      end
      return val;
   endfunction

   assign out_free = !valid_ff || rsp.ready;
   assign emit     = work_valid_ff && out_free;
   assign at_last  = (pos_ff == (work_ff.total - TW'(1)));
   assign q_pop    = q_valid && (!work_valid_ff || (emit && at_last));
   assign tail_pos = pos_ff - TW'(work_ff.vcount);

   // Pick the byte at the current position
   always_comb begin
      byte_in = byte_ff;
      ref_in  = ref_ff;
      last_in = last_ff;
      if (emit) begin
         last_in = at_last;
         if (pos_ff < TW'(work_ff.vcount)) begin
            ref_in  = 1'b0;
            byte_in = '0;
            for (int i = 0; i < hed_pkg::PENDING_DEPTH; i++) begin
               if (pos_ff == TW'(i)) begin
                  byte_in = work_ff.vbytes[i];
               end
            end
         end else if (!work_ff.tail_ref) begin
            ref_in  = 1'b0;
            byte_in = work_ff.tail_cp[7:0];
         end else begin
            ref_in  = 1'b1;
            byte_in = utf8_byte(work_ff.tail_cp, work_ff.tail_len, tail_pos[1:0]);
         end
      end
   end

   // Load the next command, advance through the current one
   always_comb begin
      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      pos_in        = pos_ff;
      if (q_pop) begin
         work_in       = q_data;
         work_valid_in = 1'b1;
         pos_in        = '0;
      end else if (emit && at_last) begin
         work_valid_in = 1'b0;
      end else if (emit) begin
         pos_in = pos_ff + TW'(1);
      end
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         pos_ff        <= '0;
         valid_ff      <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         pos_ff        <= pos_in;
         valid_ff      <= valid_in;
      end
   end

   // Command and response payload
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      byte_ff <= byte_in;
      ref_ff  <= ref_in;
      last_ff <= last_in;
   end

   assign rsp.valid          = valid_ff;
   assign rsp.out_byte       = byte_ff;
   assign rsp.from_reference = ref_ff;
   assign rsp.last_of_run    = last_ff;

   `HED_ASSERT(a_pos_in_range, work_valid_ff |-> pos_ff < work_ff.total, "position past command end")

endmodule

>>> hdl/html_entity_to_utf8_decoder.sv
// ============================================================================
// HTML entity to UTF-8 decoder
// Decodes HTML character references in a byte stream into UTF-8 text;
// failed or cut-off references pass through verbatim.
// ============================================================================
//
//   channel   dir   handshake     payload
//   req_ch    in    valid/ready   in_byte, end_of_text
//   rsp_ch    out   valid/ready   out_byte, from_reference, last_of_run
//
// The front end takes a request while the two-entry command queue has room;
// a request that yields no bytes pushes no command to the queue.
// The emitter sends one response byte per cycle while the response channel
// is not stalled (0 to 11 bytes per request); when idle it first loads a command
// from the queue into its work register, and the emitter sets the sustained rate.
// Reset is synchronous. A stalled response holds the emitter and
// the queue lets the front end keep taking requests until it fills.
// ============================================================================
`timescale 1ns / 1ps

module html_entity_to_utf8_decoder #(
   parameter int MAX_DIGITS = hed_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   hed_req_if.sink   req_ch,
   hed_rsp_if.source rsp_ch
);

   hed_pkg::cmd_type  front_cmd;
   logic              front_push;
   logic              queue_full;
   logic              queue_pop;
   logic              queue_valid;
   hed_pkg::cmd_type  queue_cmd;

   // Parse and classify requests
   hed_front #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .cmd      (front_cmd),
      .cmd_push (front_push),
      .cmd_full (queue_full)
   );

   // Decouple parsing from output
   hed_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_valid (queue_valid),
      .pop_data  (queue_cmd)
   );

   // Emit bytes
   hed_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (queue_valid),
      .q_data  (queue_cmd),
      .q_pop   (queue_pop),
      .rsp     (rsp_ch)
   );

endmodule

>>> verif/testbench.sv
// ============================================================================
// HTML entity to UTF-8 decoder testbench
// Drives text bytes into the decoder and keeps a cycle-free model of the
// reference parser. Each response byte is checked against the oldest
// predicted byte. Directed named and numeric cases run first, then
// randomized text that is mostly well-formed references with random content.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

   localparam int DIGIT_LIMIT  = 7;
   localparam int RANDOM_BYTES = 80;
   localparam int QUIET_TAIL   = 40;

   typedef enum logic [4:0] {
      MODE_TEXT = 5'b00001,
      MODE_NAME = 5'b00010,
      MODE_HASH = 5'b00100,
      MODE_DEC  = 5'b01000,
      MODE_HEX  = 5'b10000
   } ref_mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       from_reference;
      logic       last_of_run;
   } utf8_out_type;

   logic clock;
   logic reset;

   hed_req_if req_if ();
   hed_rsp_if rsp_if ();

   html_entity_to_utf8_decoder #(
      .MAX_DIGITS(DIGIT_LIMIT)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   // Named references and the characters they stand for
   string      named_refs[4]      = '{"quot", "amp", "lt", "gt"};
   logic [7:0] named_ref_chars[4] = '{8'h22, 8'h26, 8'h3C, 8'h3E};

   // Parser model state
   ref_mode_type dec_mode;
   logic [7:0]   held_bytes[hed_pkg::PENDING_DEPTH];
   int unsigned  held_count;
   int unsigned  code_sum;
   bit           code_too_big;
   int unsigned  ndigits;
   logic [3:0]   name_hits;

   utf8_out_type step_bytes[$];
   utf8_out_type expected_bytes[$];
   int           fail_count = 0;
   bit           idle_on    = 1'b1;

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------

   function automatic void put_out(logic [7:0] b, bit from_ref);
      utf8_out_type r;
      r.out_byte       = b;
      r.from_reference = from_ref;
      r.last_of_run    = 1'b0;
      step_bytes.push_back(r);
   endfunction

   function automatic void clear_ref();
      dec_mode     = MODE_TEXT;
      held_count   = 0;
      code_sum     = 0;
      code_too_big = 1'b0;
      ndigits      = 0;
      name_hits    = hed_pkg::CAND_ALL;
   endfunction

   // Emit held reference bytes verbatim and go back to text
   function automatic void flush_held();
      for (int i = 0; i < held_count; i++)
         put_out(held_bytes[i], 1'b0);
      clear_ref();
   endfunction

   function automatic bit hold_byte(logic [7:0] b);
      if (held_count >= hed_pkg::PENDING_DEPTH)
         return 1'b0;
      held_bytes[held_count] = b;
      held_count++;
      return 1'b1;
   endfunction

   // Pass a byte through, or open a reference on an ampersand
   function automatic void plain_text(logic [7:0] b);
      if (b == hed_pkg::CHAR_AMP) begin
         clear_ref();
         held_bytes[0] = b;
         held_count    = 1;
         dec_mode      = MODE_NAME;
      end else begin
         put_out(b, 1'b0);
      end
   endfunction

   function automatic void abandon_ref(logic [7:0] b);
      flush_held();
      plain_text(b);
   endfunction

   function automatic void put_utf8(logic [20:0] cp);
      if (cp <= 21'h7F) begin
         put_out(cp[7:0], 1'b1);
      end else if (cp <= 21'h7FF) begin
         put_out({3'b110, cp[10:6]}, 1'b1);
         put_out({2'b10, cp[5:0]}, 1'b1);
      end else if (cp <= 21'hFFFF) begin
         put_out({4'b1110, cp[15:12]}, 1'b1);
         put_out({2'b10, cp[11:6]}, 1'b1);
         put_out({2'b10, cp[5:0]}, 1'b1);
      end else begin
         put_out({5'b11110, cp[20:18]}, 1'b1);
         put_out({2'b10, cp[17:12]}, 1'b1);
         put_out({2'b10, cp[11:6]}, 1'b1);
         put_out({2'b10, cp[5:0]}, 1'b1);
      end
   endfunction

   function automatic int digit_of(logic [7:0] b, bit hex);
      if (b >= 8'h30 && b <= 8'h39)
         return int'(b) - 'h30;
      if (hex && b >= 8'h61 && b <= 8'h66)
         return int'(b) - 'h61 + 10;
      if (hex && b >= 8'h41 && b <= 8'h46)
         return int'(b) - 'h41 + 10;
      return -1;
   endfunction

   // Accumulate one digit; saturate and flag values past the code point limit
   function automatic bit take_digit(logic [7:0] b, bit hex);
      int          d;
      int unsigned v;
      d = digit_of(b, hex);
      if (d < 0 || ndigits >= DIGIT_LIMIT || !hold_byte(b))
         return 1'b0;
      v = code_sum * (hex ? 16 : 10) + d;
      if (v > hed_pkg::CODE_MAX) begin
         code_too_big = 1'b1;
         v            = hed_pkg::CODE_MAX;
      end
      code_sum = v;
      ndigits++;
      return 1'b1;
   endfunction

   // Advance a named reference, narrowing the names still possible
   function automatic void name_step(logic [7:0] b);
      int unsigned pos;
      logic [3:0]  keep;
      pos  = held_count - 1;
      keep = '0;
      if (pos == 0 && b == hed_pkg::CHAR_HASH) begin
         if (hold_byte(b))
            dec_mode = MODE_HASH;
         else
            abandon_ref(b);
         return;
      end
      if (b == hed_pkg::CHAR_SEMI) begin
         for (int i = 0; i < 4; i++) begin
            if (name_hits[i] && named_refs[i].len() == pos) begin
               clear_ref();
               put_out(named_ref_chars[i], 1'b1);
               return;
            end
         end
         abandon_ref(b);
         return;
      end
      for (int i = 0; i < 4; i++) begin
         if (name_hits[i] && pos < named_refs[i].len() && named_refs[i][pos] == b)
            keep[i] = 1'b1;
      end
      if (keep == '0 || !hold_byte(b))
         abandon_ref(b);
      else
         name_hits = keep;
   endfunction

   // Work out the response bytes of one accepted request
   function automatic void decode_step(logic [7:0] b, logic eot);
      logic [20:0] cp;
      step_bytes.delete();
      case (dec_mode)
         MODE_NAME: begin
            name_step(b);
         end
         MODE_HASH: begin
            if (b == hed_pkg::CHAR_X_LO || b == hed_pkg::CHAR_X_UP) begin
               if (hold_byte(b))
                  dec_mode = MODE_HEX;
               else
                  abandon_ref(b);
            end else if (take_digit(b, 1'b0)) begin
               dec_mode = MODE_DEC;
            end else begin
               abandon_ref(b);
            end
         end
         MODE_DEC, MODE_HEX: begin
            if (b == hed_pkg::CHAR_SEMI) begin
               if (ndigits > 0 && !code_too_big) begin
                  cp = code_sum[20:0];
                  clear_ref();
                  put_utf8(cp);
               end else begin
                  abandon_ref(b);
               end
            end else if (!take_digit(b, dec_mode == MODE_HEX)) begin
               abandon_ref(b);
            end
         end
         default: begin
            clear_ref();
            plain_text(b);
         end
      endcase
      if (eot && dec_mode != MODE_TEXT)
         flush_held();
      if (step_bytes.size() > 0)
         step_bytes[step_bytes.size() - 1].last_of_run = 1'b1;
      foreach (step_bytes[i])
         expected_bytes.push_back(step_bytes[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Clock, timeout and response side
   // ------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("html_entity_to_utf8_decoder test failed");
      $finish;
   end

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%s", msg);
   endfunction

   // Stall the response channel in short random bursts
   initial begin : rsp_stall
      int stall_left;
      stall_left    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left   = $urandom_range(1, 3) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Compare each response byte with the oldest predicted byte
   always @(posedge clock) begin : rsp_check
      utf8_out_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_bytes.size() == 0) begin
            note_failure($sformatf("unexpected response: out_byte=%02h from_reference=%0b %s%0b",
                                   rsp_if.out_byte, rsp_if.from_reference,
                                   "last_of_run=", rsp_if.last_of_run));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_if.out_byte !== want.out_byte ||
                rsp_if.from_reference !== want.from_reference ||
                rsp_if.last_of_run !== want.last_of_run) begin
               note_failure($sformatf({"response mismatch: expected %02h/%0b/%0b, ",
                                       "got %02h/%0b/%0b (out_byte/from_reference/last_of_run)"},
                                      want.out_byte, want.from_reference, want.last_of_run,
                                      rsp_if.out_byte, rsp_if.from_reference,
                                      rsp_if.last_of_run));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Send one request, with an occasional idle burst ahead of it
   task automatic send_byte(input logic [7:0] b, input logic eot);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid       <= 1'b1;
      req_if.in_byte     <= b;
      req_if.end_of_text <= eot;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      decode_step(b, eot);
   endtask

   // Send a string; optionally mark its last byte as end of text
   task automatic send_text(input string s, input bit eot_last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], eot_last && i == s.len() - 1);
   endtask

   // Hold requests off until every predicted byte has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Plain bytes at the extremes, all named references, failed and cut-off names
   task automatic test_named_refs();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("A&quot;&amp;&lt;&gt;", 1'b0);
      send_text("&QUOT;&qu;&foo;&;&&lt;&gto;", 1'b0);
      send_text("&am", 1'b1);
      send_text("&", 1'b1);
   endtask

   // UTF-8 length boundaries, code point zero, surrogates, digit limit, overflow
   task automatic test_numeric_refs();
      send_text("&#0;&#65;&#x7F;&#x80;&#x7ff;&#X800;&#xFFFF;&#x10000;&#x1FFFFF;", 1'b0);
      send_text("&#2097151;&#xD800;&#x0000041;&#x00000041;&#xaBcDe;", 1'b0);
      send_text("&#x200000;&#2097152;&#12345678;&#;&#x;&#1a;&#&amp;", 1'b0);
      send_text("&#x12g&#x4", 1'b1);
   endtask

   // Random text: mostly references with random content, plus noise
   task automatic test_random_text();
      logic [7:0] chunk[$];
      int         sent;
      int         kind;
      int         n;
      int         d;
      bit         hex;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         if (sent >= RANDOM_BYTES - QUIET_TAIL)
            idle_on = 1'b0;
         chunk.delete();
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2: begin
               repeat ($urandom_range(1, 4))
                  chunk.push_back(8'($urandom_range(0, 255)));
            end
            3, 4: begin
               n = $urandom_range(0, 3);
               chunk.push_back(hed_pkg::CHAR_AMP);
               for (int i = 0; i < named_refs[n].len(); i++)
                  chunk.push_back(named_refs[n][i]);
               case ($urandom_range(0, 5))
                  0: void'(chunk.pop_back());
                  1: chunk[$urandom_range(1, chunk.size() - 1)] = 8'($urandom_range('h61, 'h7A));
                  default: ;
               endcase
               if ($urandom_range(0, 7) != 0)
                  chunk.push_back(hed_pkg::CHAR_SEMI);
            end
            5, 6, 7, 8: begin
               hex = (kind >= 7);
               chunk.push_back(hed_pkg::CHAR_AMP);
               chunk.push_back(hed_pkg::CHAR_HASH);
               if (hex)
                  chunk.push_back($urandom_range(0, 1) ? hed_pkg::CHAR_X_LO
                                                       : hed_pkg::CHAR_X_UP);
               if ($urandom_range(0, 7) == 0)
                  n = $urandom_range(0, DIGIT_LIMIT + 1);
               else
                  n = $urandom_range(1, hex ? 5 : 6);
               repeat (n) begin
                  d = $urandom_range(0, hex ? 15 : 9);
                  if (d < 10)
                     chunk.push_back(8'('h30 + d));
                  else
                     chunk.push_back(8'(($urandom_range(0, 1) ? 'h61 : 'h41) + d - 10));
               end
               if ($urandom_range(0, 7) != 0)
                  chunk.push_back(hed_pkg::CHAR_SEMI);
               else
                  chunk.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
               chunk.push_back(hed_pkg::CHAR_AMP);
               repeat ($urandom_range(0, 3)) begin
                  case ($urandom_range(0, 4))
                     0: chunk.push_back(hed_pkg::CHAR_HASH);
                     1: chunk.push_back(hed_pkg::CHAR_X_LO);
                     2: chunk.push_back(hed_pkg::CHAR_SEMI);
                     3: chunk.push_back(hed_pkg::CHAR_AMP);
                     default: chunk.push_back(8'($urandom_range(0, 255)));
                  endcase
               end
            end
         endcase
         foreach (chunk[i]) begin
            send_byte(chunk[i], $urandom_range(0, 29) == 0);
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      req_if.valid       = 1'b0;
      req_if.in_byte     = 8'h00;
      req_if.end_of_text = 1'b0;
      reset              = 1'b1;
      foreach (held_bytes[i])
         held_bytes[i] = 8'h00;
      clear_ref();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_named_refs();
      wait_for_results();
      test_numeric_refs();
      wait_for_results();
      test_random_text();
      wait_for_results();

      // Let any stray response bytes show up
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("html_entity_to_utf8_decoder test passed");
      else
         $display("html_entity_to_utf8_decoder test failed");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/hed_pkg.sv
hdl/hed_if.sv
hdl/hed_front.sv
hdl/hed_cmd_queue.sv
hdl/hed_back.sv
hdl/html_entity_to_utf8_decoder.sv
verif/testbench.sv
